// ===== rtl/keyframe_linear_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// keyframe linear sampler assertion macros
// concurrent checks on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_SAMPLER_ASSERT_SVH
`define KEYFRAME_LINEAR_SAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define KLS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keyframe sampler check failed");

`define KLS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyframe sampler sequence check failed");

`else

`define KLS_ASSERT(name, prop)

`define KLS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// types and constants shared by the keyframe linear sampler
// ----------------------------------------------------------------------------
package kls_pkg;

  localparam int DATA_W    = 32;
  localparam int SEG_W     = 6;
  localparam int SLOT_W    = 6;
  localparam int KC_W      = 7;
  localparam int NUM_SLOTS = 64;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_FIRST  = 2'd1,
    ST_LAST   = 2'd2
  } sample_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_FIN
  } state_e;

  typedef logic [2:0][DATA_W-1:0] vec3_t;

  typedef struct packed {
    logic                valid;
    logic                done;
    sample_status_e      status;
    logic [SEG_W-1:0]    seg;
    logic [DATA_W-1:0]   q;
    logic [DATA_W-1:0]   lo_time;
    vec3_t               lo_val;
    logic [DATA_W-1:0]   hi_time;
    vec3_t               hi_val;
  } token_t;

endpackage

// ===== rtl/kls_cell.sv =====
// ----------------------------------------------------------------------------
// kls_cell
// one keyframe slot; checks the passing query against its segment
// ----------------------------------------------------------------------------
module kls_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        first_i,
  input  logic                        active_i,
  input  logic                        last_i,
  input  logic [kls_pkg::SEG_W-1:0]   idx_i,
  input  logic                        wr_en_i,
  input  logic [kls_pkg::DATA_W-1:0]  wr_time_i,
  input  kls_pkg::vec3_t              wr_val_i,
  input  kls_pkg::token_t             tok_i,
  output kls_pkg::token_t             tok_o
);
  import kls_pkg::*;

  logic [DATA_W-1:0] key_time_q;
  vec3_t             key_val_q;
  logic              valid_q;
  token_t            tok_q;
  token_t            tok_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_time_q <= wr_time_i;
      key_val_q  <= wr_val_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done && active_i) begin
      if (first_i) begin
        tok_d.lo_time = key_time_q;
        tok_d.lo_val  = key_val_q;
        tok_d.seg     = idx_i;
        if (last_i || ($signed(tok_i.q) <= $signed(key_time_q))) begin
          tok_d.done   = 1'b1;
          tok_d.status = ST_FIRST;
        end
      end else if (($signed(tok_i.lo_time) <= $signed(tok_i.q)) &&
                   ($signed(tok_i.q) <= $signed(key_time_q))) begin
        tok_d.done    = 1'b1;
        tok_d.status  = ST_INTERP;
        tok_d.hi_time = key_time_q;
        tok_d.hi_val  = key_val_q;
      end else begin
        tok_d.lo_time = key_time_q;
        tok_d.lo_val  = key_val_q;
        tok_d.seg     = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ===== rtl/kls_div.sv =====
// ----------------------------------------------------------------------------
// kls_div
// restoring divider for the segment fraction, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kls_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kls_pkg::DATA_W-1:0]  num_i,
  input  logic [kls_pkg::DATA_W-1:0]  den_i,
  output logic                        done_o,
  output logic [FRAC_BITS:0]          quot_o
);
  import kls_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 2);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] den_q;
  logic [FRAC_BITS:0] quot_q;
  logic              ge;
  logic [DATA_W:0]   rdiff;

  assign ge    = rem_q >= {1'b0, den_q};
  assign rdiff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(FRAC_BITS + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {rdiff[DATA_W-1:0], 1'b0};
      quot_q <= {quot_q[FRAC_BITS-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/keyframe_linear_sampler.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_sampler
// piecewise linear sampling of an xyz keyframe table held in a chain of cells
// ----------------------------------------------------------------------------
// load request: no result
// query: walks the key chain, one cell a cycle; a clamped result is given after the walk,
//   an interpolated one after a bit-serial divider and one multiplier shared over
//   x, y and z; the next request is taken in the result cycle
// reset: key_count becomes 1, keys undefined until loaded; done_o cannot be stalled
module keyframe_linear_sampler #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [kls_pkg::SLOT_W-1:0]  key_slot_i,
  input  logic [kls_pkg::DATA_W-1:0]  key_time_i,
  input  logic [kls_pkg::DATA_W-1:0]  key_x_i,
  input  logic [kls_pkg::DATA_W-1:0]  key_y_i,
  input  logic [kls_pkg::DATA_W-1:0]  key_z_i,
  input  logic [kls_pkg::DATA_W-1:0]  query_time_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kls_pkg::KC_W-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic [kls_pkg::DATA_W-1:0]  out_x_o,
  output logic [kls_pkg::DATA_W-1:0]  out_y_o,
  output logic [kls_pkg::DATA_W-1:0]  out_z_o,
  output logic [kls_pkg::SEG_W-1:0]   segment_o,
  output logic [1:0]                  sample_status_o
);
  import kls_pkg::*;

  `include "keyframe_linear_sampler_assert.svh"

  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int PW = DATA_W + FRAC_BITS + 3;

  state_e state_q, state_d;

  logic [KC_W-1:0]    key_count_q;
  logic [NW-1:0]      n_eff;
  logic               acc;
  logic               load_acc;
  logic               query_acc;
  vec3_t              wr_val;
  token_t             chain [MAX_KEYS+1];
  token_t             tail;
  logic               tail_interp;

  logic               div_start;
  logic               cap_tail;
  logic               clamp_emit;
  logic               mul_en;
  logic               fin;

  logic signed [DATA_W:0] dq;
  logic signed [DATA_W:0] dh;
  logic               div_done;
  logic [FRAC_BITS:0] div_quot;

  token_t             tok_q;
  logic               zero_den_q;
  logic [FRAC_BITS:0] t_q;
  logic [1:0]         mul_idx_q;
  logic [1:0]         prod_idx_q;
  logic               prod_vld_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] diff_w;
  logic signed [PW-1:0] t_w;
  logic signed [PW-1:0] sum_w;
  logic               done_q;
  vec3_t              res_val_q;
  logic [SEG_W-1:0]   seg_q;
  sample_status_e     status_q;

  // request handshake and configuration
  assign acc         = start && !busy;
  assign load_acc    = acc && (req_type_i == REQ_LOAD);
  assign query_acc   = acc && (req_type_i == REQ_QUERY);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KC_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (key_count_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = NW'(key_count_q);
    end
  end

  // key chain
  assign wr_val = {key_z_i, key_y_i, key_x_i};

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = query_acc;
    chain[0].q     = query_time_i;
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic wr_en;
    if (i < NUM_SLOTS) begin : g_wr
      assign wr_en = load_acc && (key_slot_i == SLOT_W'(i));
    end else begin : g_nowr
      assign wr_en = 1'b0;
    end
    kls_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .first_i   (i == 0),
      .active_i  (NW'(i) < n_eff),
      .last_i    (NW'(i) == (n_eff - NW'(1))),
      .idx_i     (SEG_W'(i)),
      .wr_en_i   (wr_en),
      .wr_time_i (key_time_i),
      .wr_val_i  (wr_val),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1])
    );
  end

  assign tail        = chain[MAX_KEYS];
  assign tail_interp = tail.valid && tail.done && (tail.status == ST_INTERP);

  // fraction divider
  assign dq = $signed({tail.q[DATA_W-1], tail.q}) -
              $signed({tail.lo_time[DATA_W-1], tail.lo_time});
  assign dh = $signed({tail.hi_time[DATA_W-1], tail.hi_time}) -
              $signed({tail.lo_time[DATA_W-1], tail.lo_time});

  kls_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dq[DATA_W-1:0]),
    .den_i   (dh[DATA_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (query_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_d = tail_interp ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_idx_q == 2'd2) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = (state_q != S_IDLE);
    cap_tail   = (state_q == S_SCAN) && tail.valid;
    div_start  = cap_tail && tail_interp;
    clamp_emit = cap_tail && !tail_interp;
    mul_en     = (state_q == S_MUL);
    fin        = (state_q == S_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      mul_idx_q  <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= clamp_emit || fin;
      prod_vld_q <= mul_en;
      mul_idx_q  <= (mul_en && (mul_idx_q != 2'd2)) ? (mul_idx_q + 2'd1) : 2'd0;
    end
  end

  // interpolation datapath
  always_comb begin
    diff_w = PW'($signed(tok_q.hi_val[mul_idx_q])) - PW'($signed(tok_q.lo_val[mul_idx_q]));
    t_w    = PW'($signed({1'b0, t_q}));
    sum_w  = PW'($signed(tok_q.lo_val[prod_idx_q])) + (prod_q >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (cap_tail) begin
      tok_q      <= tail;
      zero_den_q <= (dh == '0);
      seg_q      <= tail.seg;
      status_q   <= tail.done ? tail.status : ST_LAST;
    end
    if (clamp_emit) begin
      res_val_q <= tail.lo_val;
    end
    if (div_done) begin
      t_q <= zero_den_q ? '0 : div_quot;
    end
    if (mul_en) begin
      prod_q     <= diff_w * t_w;
      prod_idx_q <= mul_idx_q;
    end
    if (prod_vld_q) begin
      res_val_q[prod_idx_q] <= sum_w[DATA_W-1:0];
    end
  end

  assign done_o          = done_q;
  assign out_x_o         = res_val_q[0];
  assign out_y_o         = res_val_q[1];
  assign out_z_o         = res_val_q[2];
  assign segment_o       = seg_q;
  assign sample_status_o = status_q;

  `KLS_ASSERT(a_done_when_idle, done_o |-> !busy)
  `KLS_ASSERT_NEXT(a_query_goes_busy, start && !busy && (req_type_i == REQ_QUERY), busy)
  `KLS_ASSERT_NEXT(a_load_no_result, start && !busy && (req_type_i == REQ_LOAD), !done_o)
  `KLS_ASSERT_NEXT(a_single_strobe, done_o, !done_o)

endmodule

// ===== tb/sv/tb_keyframe_linear_sampler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_sampler
// self-checking bench for the keyframe linear sampler: a directed table of
// load and query requests, then random phases that rebuild the key table in
// time order and sample it inside segments, on key times and at random
// times, each phase under its own key count; every sample is compared
// against the row's given sample or a local model of the table
// ----------------------------------------------------------------------------
module tb_keyframe_linear_sampler;
  import kls_pkg::*;

  localparam int          FRAC          = 16;
  localparam int          DRAIN_CYCLES  = 100;
  localparam int          STALL_LIMIT   = 5000;
  localparam int          NUM_PHASES    = 10;
  localparam int          MIXED_ITEMS   = 26;
  localparam int          N_DIR         = 26;
  localparam logic [31:0] V_MAX         = 32'h7fffffff;
  localparam logic [31:0] V_MIN         = 32'h80000000;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [SEG_W-1:0]  seg;
    sample_status_e    status;
  } sample_t;

  typedef struct {
    bit          cfg_row;
    logic [6:0]  cfg_val;
    req_type_e   kind;
    logic [5:0]  slot;
    logic [31:0] ktime;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [31:0] q;
    bit          typed;
    sample_t     want;
  } dir_row_t;

  localparam sample_t NO_SAMPLE = '0;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic        req_type_i   = 1'b0;
  logic [5:0]  key_slot_i   = '0;
  logic [31:0] key_time_i   = '0;
  logic [31:0] key_x_i      = '0;
  logic [31:0] key_y_i      = '0;
  logic [31:0] key_z_i      = '0;
  logic [31:0] query_time_i = '0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_wdata_i  = '0;
  logic        done_o;
  logic [31:0] out_x_o;
  logic [31:0] out_y_o;
  logic [31:0] out_z_o;
  logic [5:0]  segment_o;
  logic [1:0]  sample_status_o;

  logic signed [31:0] key_time_tbl [NUM_SLOTS];
  logic signed [31:0] key_val_tbl  [NUM_SLOTS][3];
  logic [6:0]         key_count_reg = 7'd1;
  sample_t            pending_samples [$];
  sample_t            want_sample;
  int                 mismatch_count = 0;
  int                 stall_cycles   = 0;
  bit                 idle_on        = 1'b1;

  dir_row_t dir_rows [N_DIR] = '{
    '{0, 7'd0, REQ_LOAD, 6'd0, 32'h0, V_MAX, V_MIN, 32'h0, 32'h0, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MIN, 1,
      '{V_MAX, V_MIN, 32'h0, 6'd0, ST_FIRST}},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MAX, 1,
      '{V_MAX, V_MIN, 32'h0, 6'd0, ST_FIRST}},
    '{1, 7'd2, REQ_LOAD, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_LOAD, 6'd1, 32'h10000, V_MIN, V_MAX, 32'hffffffff, 32'h0, 0,
      NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1,
      '{V_MAX, V_MIN, 32'h0, 6'd0, ST_FIRST}},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 1,
      '{V_MIN, V_MAX, 32'hffffffff, 6'd0, ST_INTERP}},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MAX, 1,
      '{V_MIN, V_MAX, 32'hffffffff, 6'd1, ST_LAST}},
    '{1, 7'd0, REQ_LOAD, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MAX, 1,
      '{V_MAX, V_MIN, 32'h0, 6'd0, ST_FIRST}},
    '{1, 7'd3, REQ_LOAD, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, NO_SAMPLE},
    // zero-length first segment
    '{0, 7'd0, REQ_LOAD, 6'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_LOAD, 6'd2, V_MAX, V_MIN, V_MAX, 32'h12345678, 32'h0, 0,
      NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1,
      '{V_MAX, V_MIN, 32'h0, 6'd0, ST_FIRST}},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7ffffffe, 0,
      NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MAX, 1,
      '{V_MIN, V_MAX, 32'h12345678, 6'd1, ST_INTERP}},
    '{1, 7'd127, REQ_LOAD, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_LOAD, 6'd0, V_MIN, 32'hffffffff, 32'h1, V_MIN, 32'h0, 0,
      NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MIN, 1,
      '{32'hffffffff, 32'h1, V_MIN, 6'd0, ST_FIRST}},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, V_MAX, 0, NO_SAMPLE},
    '{0, 7'd0, REQ_LOAD, 6'd63, V_MAX, 32'h1, 32'hffffffff, 32'h0, 32'h0, 0,
      NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h40000000, 0,
      NO_SAMPLE},
    '{0, 7'd0, REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000001, 0,
      NO_SAMPLE}
  };

  keyframe_linear_sampler #(
    .MAX_KEYS  (NUM_SLOTS),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .key_slot_i      (key_slot_i),
    .key_time_i      (key_time_i),
    .key_x_i         (key_x_i),
    .key_y_i         (key_y_i),
    .key_z_i         (key_z_i),
    .query_time_i    (query_time_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .segment_o       (segment_o),
    .sample_status_o (sample_status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic sample_t sample_keys(input logic signed [31:0] q);
    sample_t r;
    int      n;
    int      k;
    longint  lo;
    longint  hi;
    longint  frac;
    longint  a;
    longint  d;
    logic [31:0] v [3];
    n = (key_count_reg == 0) ? 1 : (key_count_reg > NUM_SLOTS) ? NUM_SLOTS : key_count_reg;
    k = n - 1;
    r = '0;
    r.status = ST_LAST;
    r.seg = 6'(n - 1);
    if (n == 1 || q <= key_time_tbl[0]) begin
      k = 0;
      r.status = ST_FIRST;
      r.seg = '0;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        lo = key_time_tbl[i];
        hi = key_time_tbl[i+1];
        if (lo <= q && q <= hi) begin
          frac = (hi == lo) ? 0 : ((longint'(q) - lo) <<< FRAC) / (hi - lo);
          for (int c = 0; c < 3; c++) begin
            a = key_val_tbl[i][c];
            d = longint'(key_val_tbl[i+1][c]) - a;
            v[c] = 32'(a + ((d * frac) >>> FRAC));
          end
          r.x = v[0];
          r.y = v[1];
          r.z = v[2];
          r.seg = 6'(i);
          r.status = ST_INTERP;
          return r;
        end
      end
    end
    r.x = key_val_tbl[k][0];
    r.y = key_val_tbl[k][1];
    r.z = key_val_tbl[k][2];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return V_MAX;
      1:       return V_MIN;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input req_type_e kind, input logic [5:0] slot,
                              input logic [31:0] kt, input logic [31:0] kx,
                              input logic [31:0] ky, input logic [31:0] kz,
                              input logic [31:0] q, input bit typed,
                              input sample_t want);
    if (idle_on && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start        <= 1'b1;
    req_type_i   <= kind;
    key_slot_i   <= slot;
    key_time_i   <= kt;
    key_x_i      <= kx;
    key_y_i      <= ky;
    key_z_i      <= kz;
    query_time_i <= q;
    do @(posedge clk_i); while (busy);
    if (kind == REQ_LOAD) begin
      key_time_tbl[slot]   = kt;
      key_val_tbl[slot][0] = kx;
      key_val_tbl[slot][1] = ky;
      key_val_tbl[slot][2] = kz;
    end else if (typed) begin
      pending_samples.insert(pending_samples.size(), want);
    end else begin
      pending_samples.insert(pending_samples.size(), sample_keys(q));
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key_count(input logic [6:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    key_count_reg = v;
  endtask

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected sample: x=%h y=%h z=%h seg=%0d status=%0d",
                   out_x_o, out_y_o, out_z_o, segment_o, sample_status_o);
      end else begin
        want_sample = pending_samples.pop_front();
        if (out_x_o !== want_sample.x || out_y_o !== want_sample.y ||
            out_z_o !== want_sample.z || segment_o !== want_sample.seg ||
            sample_status_o !== want_sample.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("sample mismatch: want x=%h y=%h z=%h seg=%0d status=%0d, ",
                   want_sample.x, want_sample.y, want_sample.z, want_sample.seg,
                   want_sample.status);
            $display("got x=%h y=%h z=%h seg=%0d status=%0d",
                     out_x_o, out_y_o, out_z_o, segment_o, sample_status_o);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    int          p;
    int          s;
    int          k;
    int          n;
    int          pick;
    int          seg_i;
    logic [5:0]  slot;
    logic [6:0]  kc;
    longint      base;
    longint      step;
    longint      kt;
    longint      lo;
    longint      hi;
    logic [31:0] qv;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot so that no query reads an unwritten key
    for (s = 0; s < NUM_SLOTS; s++)
      send_request(REQ_LOAD, 6'(s), 32'(longint'(s - 32) * 65536), pick_value(),
                   pick_value(), pick_value(), $urandom, 0, NO_SAMPLE);

    for (k = 0; k < N_DIR; k++) begin
      if (dir_rows[k].cfg_row)
        write_key_count(dir_rows[k].cfg_val);
      else
        send_request(dir_rows[k].kind, dir_rows[k].slot, dir_rows[k].ktime,
                     dir_rows[k].kx, dir_rows[k].ky, dir_rows[k].kz,
                     dir_rows[k].q, dir_rows[k].typed, dir_rows[k].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       kc = 7'd64;
        1:       kc = 7'd1;
        2:       kc = 7'd127;
        3:       kc = 7'd0;
        default: kc = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(65, 127))
                                                  : 7'($urandom_range(2, 64));
      endcase
      idle_on = (p != 5);
      write_key_count(kc);
      n = (kc == 0) ? 1 : (kc > NUM_SLOTS) ? NUM_SLOTS : kc;
      base = longint'($signed($urandom)) >>> 2;
      case ($urandom_range(0, 3))
        0:       step = $urandom_range(1, 8);
        1:       step = $urandom_range(1, 32'hffff);
        2:       step = $urandom_range(32'h10000, 32'h100000);
        default: step = $urandom_range(32'h100000, 32'h1000000);
      endcase

      // rebuild the keys in use in time order, some times repeated
      kt = base;
      for (s = 0; s < n; s++) begin
        if (s > 0 && $urandom_range(0, 7) != 0)
          kt = kt + longint'($urandom_range(1, 32'(step)));
        send_request(REQ_LOAD, 6'(s), 32'(kt), pick_value(), pick_value(),
                     pick_value(), $urandom, 0, NO_SAMPLE);
      end

      for (k = 0; k < MIXED_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          if (pick < 15) begin
            slot = 6'($urandom_range(0, n - 1));
            kt   = key_time_tbl[slot];
          end else begin
            slot = 6'($urandom_range(0, NUM_SLOTS - 1));
            kt   = longint'($urandom);
          end
          send_request(REQ_LOAD, slot, 32'(kt), pick_value(), pick_value(),
                       pick_value(), $urandom, 0, NO_SAMPLE);
        end else begin
          if (pick < 65 && n > 1) begin
            seg_i = $urandom_range(0, n - 2);
            lo = key_time_tbl[seg_i];
            hi = key_time_tbl[seg_i+1];
            qv = (hi > lo) ? 32'(lo + longint'($urandom) % (hi - lo + 1)) : 32'(lo);
          end else if (pick < 80) begin
            qv = key_time_tbl[$urandom_range(0, n - 1)];
          end else if (pick < 88) begin
            qv = 32'(longint'(key_time_tbl[0]) - longint'($urandom_range(0, 32'(step))));
          end else begin
            qv = $urandom;
          end
          send_request(REQ_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                       $urandom, qv, 0, NO_SAMPLE);
        end
        if ($urandom_range(0, 49) == 0)
          drain_results();
      end
    end

    drain_results();
    if (mismatch_count == 0 && pending_samples.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kls_pkg.sv
rtl/kls_cell.sv
rtl/kls_div.sv
rtl/keyframe_linear_sampler.sv
tb/sv/tb_keyframe_linear_sampler.sv
